### hw/rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Command and status codes shared by the k-way merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

	// command carried by each input word
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// status carried by each result word
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_RSVD  = 2'd3
	} status_t;

	localparam int KEY_W   = 64;
	localparam int SEL_W   = 4;
	localparam int ACTV_W  = 5;
	localparam logic [ACTV_W-1:0] ACTV_RESET = 5'd16;

endpackage

### hw/rtl/k_way_merge_unit.sv
// ----------------------------------------------------------------------------
// k_way_merge_unit
// Merges sorted runs of signed 64-bit keys held in per-stream ring buffers
// in one key memory; a pop scans the active stream heads for the minimum.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | cmd, stream_sel, key_in
//  out     | output    | out_valid / out_ready | status, key_out, source_stream, last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (active_streams)
//
// Load, clear and the unused command finish in the accept cycle; the result
// is registered and shows the next cycle.
// A pop with at least one active stream reads the key memory at the head of
// each active stream in turn, compares each read, once registered, against
// the current best, closes the scan and then, in the done state, updates the
// winning stream. With no active stream no key is read; the result is empty.
// A new word is taken only once the previous result is taken, at the
// earliest in the same cycle; a stalled receiver holds the input.
// Reset empties all streams; the key memory itself is not cleared.
// ----------------------------------------------------------------------------
module k_way_merge_unit #(
	parameter int STREAMS = 16,
	parameter int DEPTH   = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 cmd,
	input  logic [kwm_pkg::SEL_W-1:0]  stream_sel,
	input  logic signed [kwm_pkg::KEY_W-1:0] key_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic signed [kwm_pkg::KEY_W-1:0] key_out,
	output logic [kwm_pkg::SEL_W-1:0]  source_stream,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kwm_pkg::ACTV_W-1:0] cfg_data
);
	import kwm_pkg::*;

	localparam int IW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int CNTW = $clog2(STREAMS + 1);
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW   = $clog2(DEPTH + 1);
	localparam int AW   = IW + PW;
	localparam int MEMD = STREAMS * (2 ** PW);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t state_q;

	// configuration
	logic [ACTV_W-1:0] active_q;
	logic [CNTW-1:0]   act_n;

	// per-stream control
	logic [PW-1:0] head_q [STREAMS];
	logic [FW-1:0] fill_q [STREAMS];

	// key memory
	logic [KEY_W-1:0] mem [MEMD];
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	logic [KEY_W-1:0] rdata_s1;

	// scan state
	logic [CNTW-1:0]  idx_q;
	logic             rd_v_s1;
	logic [IW-1:0]    rd_str_s1;
	logic             found_q;
	logic [IW-1:0]    best_q;
	logic [KEY_W-1:0] bkey_q;

	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] key_out_q;
	logic [SEL_W-1:0] src_q;
	logic             last_q;

	logic          accept;
	logic          out_set;
	cmd_t          cmd_c;
	logic [IW-1:0] sel_i;
	logic          sel_bad;
	logic          sel_full;
	logic [PW+1:0] wsum;
	logic [PW-1:0] wpos;
	logic          better;
	logic          any_left;

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept        = in_valid && in_ready;
	assign cmd_c         = cmd_t'(cmd);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign key_out       = key_out_q;
	assign source_stream = src_q;
	assign last          = last_q;

	// a result word is produced by a non-pop accept or at the end of a pop
	assign out_set = ((state_q == ST_IDLE) && accept && (cmd_c != CMD_POP)) ||
		(state_q == ST_DONE);

	// active count clamped to the stream count
	assign act_n = (32'(active_q) > STREAMS) ? CNTW'(STREAMS) : CNTW'(active_q);

	// load target and write position in its ring
	always_comb begin
		sel_i    = IW'(stream_sel);
		sel_bad  = 32'(stream_sel) >= STREAMS;
		sel_full = sel_bad ? 1'b1 : (32'(fill_q[sel_i]) >= DEPTH);
		wsum     = (PW+2)'(head_q[sel_i]) + (PW+2)'(fill_q[sel_i]);
		if (32'(wsum) >= DEPTH) begin
			wsum = wsum - (PW+2)'(DEPTH);
		end
		wpos      = PW'(wsum);
		mem_we    = accept && (cmd_c == CMD_LOAD) && !sel_full;
		mem_waddr = {sel_i, wpos};
	end

	// scan read address
	assign mem_raddr = {IW'(idx_q), head_q[IW'(idx_q)]};

	// head compare against current best
	assign better = rd_v_s1 && (fill_q[rd_str_s1] != '0) &&
		(!found_q || ($signed(rdata_s1) < $signed(bkey_q)));

	// any active stream still holding a key once the winner is advanced
	always_comb begin
		any_left = 1'b0;
		for (int s = 0; s < STREAMS; s++) begin
			if ((CNTW'(s) < act_n) && (fill_q[s] != '0) &&
				!(found_q && (IW'(s) == best_q) && (fill_q[s] == FW'(1)))) begin
				any_left = 1'b1;
			end
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= key_in;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// control, stream pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= STS_OK;
			key_out_q   <= '0;
			src_q       <= '0;
			last_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_str_s1   <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bkey_q      <= '0;
			idx_q       <= '0;
			for (int s = 0; s < STREAMS; s++) begin
				head_q[s] <= '0;
				fill_q[s] <= '0;
			end
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q  <= ((cmd_c == CMD_LOAD) && sel_full) ? STS_FULL : STS_OK;
						key_out_q <= '0;
						src_q     <= '0;
						last_q    <= 1'b0;
						case (cmd_c)
							CMD_LOAD: begin
								if (!sel_full) begin
									fill_q[sel_i] <= fill_q[sel_i] + FW'(1);
								end
							end
							CMD_POP: begin
								state_q <= ST_SCAN;
								idx_q   <= '0;
								found_q <= 1'b0;
								rd_v_s1 <= 1'b0;
							end
							CMD_CLEAR: begin
								for (int s = 0; s < STREAMS; s++) begin
									head_q[s] <= '0;
									fill_q[s] <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
						best_q  <= rd_str_s1;
						bkey_q  <= rdata_s1;
					end
					if (idx_q < act_n) begin
						rd_v_s1   <= 1'b1;
						rd_str_s1 <= IW'(idx_q);
						idx_q     <= idx_q + CNTW'(1);
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					if (found_q) begin
						status_q  <= STS_OK;
						key_out_q <= bkey_q;
						src_q     <= SEL_W'(best_q);
						last_q    <= !any_left;
						fill_q[best_q] <= fill_q[best_q] - FW'(1);
						head_q[best_q] <= (head_q[best_q] == PW'(DEPTH - 1)) ?
							'0 : head_q[best_q] + PW'(1);
					end else begin
						status_q  <= STS_EMPTY;
						key_out_q <= '0;
						src_q     <= '0;
						last_q    <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STS_EMPTY) |-> last)
		else $error("empty pop without last");
	a_nonpop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> (key_out == '0 && source_stream == '0))
		else $error("failed word carries key");
	a_scan_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !out_valid_q)
		else $error("scan with pending result");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q[0]) <= DEPTH)
		else $error("stream 0 overfilled");

endmodule
